@@ rtl/core/uns_pkg.sv @@
// Shared types and constants for the unordered set table.
package uns_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 7;
  localparam int CMD_W          = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] element_value;
  } uns_in_t;

  typedef struct packed {
    logic               result_flag;
    logic [COUNT_W-1:0] element_count;
    logic               table_full;
  } uns_out_t;

endpackage

@@ rtl/core/uns_store.sv @@
// Element store: single write port, one registered read port.
module uns_store #(
  parameter int  DEPTH = uns_pkg::CAPACITY_DEF,
  parameter int  WIDTH = uns_pkg::ELEM_WIDTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/uns_seq.sv @@
// Command sequencer: linear scan with one shared comparator, then write-back.
module uns_seq #(
  parameter int  CAPACITY   = uns_pkg::CAPACITY_DEF,
  parameter int  ELEM_WIDTH = uns_pkg::ELEM_WIDTH_DEF,
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  uns_pkg::uns_in_t      in_item,
  output logic                  busy,
  output logic                  mem_we,
  output logic [IDX_W-1:0]      mem_waddr,
  output logic [ELEM_WIDTH-1:0] mem_wdata,
  output logic [IDX_W-1:0]      mem_raddr,
  input  logic [ELEM_WIDTH-1:0] mem_rdata,
  output logic                  res_vld,
  output uns_pkg::uns_out_t     res
);

  import uns_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ACT  = 4'b0100,
    S_MOVE = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [ELEM_WIDTH-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;

  logic [63:0]           val_ext;
  logic [CNT_W-1:0]      last_cnt;
  logic                  hit;
  logic                  at_last;
  logic                  is_full;

  assign val_ext  = 64'(in_item.element_value);
  assign last_cnt = count_r - CNT_W'(1);
  assign hit      = (mem_rdata == val_r);
  assign at_last  = (CNT_W'(cmp_idx_r) == last_cnt);
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    val_nxt     = val_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    found_nxt   = found_r;
    pos_nxt     = pos_r;
    mem_we      = 1'b0;
    mem_waddr   = count_r[IDX_W-1:0];
    mem_wdata   = val_r;
    mem_raddr   = rd_idx_r;
    res_vld     = 1'b0;
    res         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_item.command;
          val_nxt     = val_ext[ELEM_WIDTH-1:0];
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          found_nxt   = 1'b0;
          state_nxt   = (count_r == '0) ? S_ACT : S_SCAN;
        end
      end
      S_SCAN: begin
        // Read address runs one ahead of the compared entry.
        rd_idx_nxt  = rd_idx_r + IDX_W'(1);
        cmp_idx_nxt = rd_idx_r;
        cmp_vld_nxt = 1'b1;
        if (cmp_vld_r) begin
          if (hit) begin
            found_nxt = 1'b1;
            pos_nxt   = cmp_idx_r;
            state_nxt = S_ACT;
          end else if (at_last) begin
            state_nxt = S_ACT;
          end
        end
      end
      S_ACT: begin
        // Fetch last entry in case a delete needs it for the swap.
        mem_raddr = last_cnt[IDX_W-1:0];
        state_nxt = S_IDLE;
        res_vld   = 1'b1;
        unique case (cmd_r)
          CMD_ADD: begin
            if (!found_r) begin
              if (is_full) begin
                res.table_full = 1'b1;
              end else begin
                mem_we          = 1'b1;
                count_nxt       = count_r + CNT_W'(1);
                res.result_flag = 1'b1;
              end
            end
          end
          CMD_DELETE: begin
            if (found_r) begin
              state_nxt = S_MOVE;
              res_vld   = 1'b0;
            end
          end
          CMD_QUERY: begin
            res.result_flag = found_r;
          end
          default: begin
          end
        endcase
      end
      S_MOVE: begin
        mem_we          = 1'b1;
        mem_waddr       = pos_r;
        mem_wdata       = mem_rdata;
        count_nxt       = last_cnt;
        res.result_flag = 1'b1;
        res_vld         = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.element_count = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    val_r     <= val_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pos_r     <= pos_nxt;
  end

endmodule

@@ rtl/core/unordered_set_table.sv @@
// Top level of the unordered set table: sequencer, element store, result register.
//
// Usage:
//   Input channel: a command (add, delete, query) and an element value are
//   transferred at a rising edge with start high and busy low. busy stays high
//   until the cycle in which that command's result is presented.
//   Result channel: out_valid is high for exactly one cycle with out_item
//   holding the flag, the count after the command and the full indication.
//   The receiver cannot stall; each result must be taken in its cycle.
// Operation:
//   The scan reads one stored entry per cycle through the store's single
//   registered read port and one comparator, over the entries held when the
//   command starts (none when empty, stopping early on a match); then comes a
//   decide state, a further state for a delete that swaps the last entry in,
//   and the result register presents the result, when busy falls and the
//   next command can go in.
// Reset: synchronous, active low; the count is cleared, the set is empty.
//   Stored entries are not cleared: only entries below the count are used.
// Elements compare over the low ELEM_WIDTH bits of element_value.
module unordered_set_table #(
  parameter int CAPACITY   = uns_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = uns_pkg::ELEM_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  uns_pkg::uns_in_t  in_item,
  output logic              out_valid,
  output uns_pkg::uns_out_t out_item
);

  import uns_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;
  logic                  res_vld;
  uns_out_t              res;

  logic                  out_valid_r;
  uns_out_t              out_item_r;

  uns_seq #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_vld   (res_vld),
    .res       (res)
  );

  uns_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEM_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result register: one-cycle strobe, payload captured with it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
